/* design/wgvw_pkg.sv */
// shared constants, types and the sine table builder for the wavy grid vertex warp
package wgvw_pkg;

    // field and register widths
    localparam int PHASE_W    = 16;
    localparam int AMP_W      = 16;
    localparam int RATE_W     = 24;
    localparam int SIZE_W     = 7;
    localparam int IDX_W      = 6;
    localparam int TIME_W     = 16;
    localparam int POS_W      = 16;
    localparam int FRAC_W     = 14;
    localparam int TERM_W     = 18;
    localparam int SUM_W      = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 32;

    // grid limits and table size default
    localparam int MAX_COLS         = 64;
    localparam int MAX_ROWS         = 64;
    localparam int SINE_ENTRIES_DEF = 256;

    // divider operand widths: index scaled by 2^14 over size minus one
    localparam int DIV_NUM_W = IDX_W + FRAC_W;
    localparam int DIV_DEN_W = SIZE_W;

    localparam longint Q30_ONE = 64'sd1 << 30;

    // operation codes carried in tuser
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_VERTEX  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_STEP = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_X    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_Y    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLS     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 4'd7;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic tmul;
        logic tadd;
        logic vprep;
        logic vmul;
        logic out_load;
    } wgvw_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
    } wgvw_stat_t;

    // odd degree-9 polynomial for sin(pi/2 * t), t in q30, result q14
    function automatic logic [FRAC_W:0] sine_poly(longint t);
        longint t2;
        longint p;
        t2 = (t * t) / Q30_ONE;
        p  = 64'sd172272;
        p  = -64'sd5026992 + (p * t2) / Q30_ONE;
        p  = 64'sd85569305 + (p * t2) / Q30_ONE;
        p  = -64'sd693598669 + (p * t2) / Q30_ONE;
        p  = 64'sd1686629713 + (p * t2) / Q30_ONE;
        p  = (p * t) / Q30_ONE;
        p  = (p + 64'sd32768) >>> 16;
        if (p < 64'sd0) p = 64'sd0;
        if (p > 64'sd16384) p = 64'sd16384;
        return p[FRAC_W:0];
    endfunction

endpackage

/* design/wgvw_div.sv */
// restoring divider, one quotient bit per cycle
module wgvw_div #(
    parameter int NUM_W = wgvw_pkg::DIV_NUM_W,
    parameter int DEN_W = wgvw_pkg::DIV_DEN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            // shift in next dividend bit, subtract when it fits
            if (fits) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_next = trial[DEN_W-1:0];
            end
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

/* design/wgvw_dp.sv */
// datapath: config registers, phase accumulator, sine rom, dividers, wave terms, output word
module wgvw_dp #(
    parameter int SINE_ENTRIES = wgvw_pkg::SINE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [wgvw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wgvw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [wgvw_pkg::TIME_W-1:0]         in_time,
    input  logic [wgvw_pkg::IDX_W-1:0]          in_col,
    input  logic [wgvw_pkg::IDX_W-1:0]          in_row,
    input  wgvw_pkg::wgvw_cmd_t                 cmd,
    output wgvw_pkg::wgvw_stat_t                stat,
    output logic [wgvw_pkg::POS_W-1:0]          pos_x,
    output logic [wgvw_pkg::POS_W-1:0]          pos_y
);
    import wgvw_pkg::*;

    localparam int ADDR_W = $clog2(SINE_ENTRIES + 1);

    // configuration and phase
    logic [PHASE_W-1:0]       row_step_reg, row_step_next;
    logic [PHASE_W-1:0]       col_step_reg, col_step_next;
    logic signed [AMP_W-1:0]  amp_x_reg, amp_x_next;
    logic signed [AMP_W-1:0]  amp_y_reg, amp_y_next;
    logic signed [RATE_W-1:0] rate_reg, rate_next;
    logic                     split_reg, split_next;
    logic [SIZE_W-1:0]        cols_reg, cols_next;
    logic [SIZE_W-1:0]        rows_reg, rows_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic                     cfg_hit;

    // captured item
    logic [TIME_W-1:0]        time_reg;
    logic [IDX_W-1:0]         col_reg;
    logic [IDX_W-1:0]         row_reg;

    // time advance
    logic signed [TIME_W+RATE_W:0] time_prod;
    logic [PHASE_W-1:0]            delta_reg;

    // vertex setup
    logic [SIZE_W-1:0]              cols_n, rows_n;
    logic [DIV_DEN_W-1:0]           den_x, den_y;
    logic [DIV_NUM_W-1:0]           num_x, num_y;
    logic [IDX_W+PHASE_W-1:0]       row_prod, col_prod;
    logic [PHASE_W-1:0]             ph_x_reg, ph_y_reg;
    logic                           split_hit_reg;

    // sine lookup
    logic [FRAC_W:0]                sine_rom [0:SINE_ENTRIES];
    logic [FRAC_W:0]                pos_x_q, pos_y_q;
    logic [31:0]                    scaled_x, scaled_y;
    logic [ADDR_W-1:0]              addr_x, addr_y;
    logic [FRAC_W:0]                rom_x_reg, rom_y_reg;
    logic                           neg_x_reg, neg_y_reg;

    // wave terms
    logic signed [AMP_W-1:0]        sine_x, sine_y;
    logic signed [2*AMP_W-1:0]      prod_x, prod_y;
    logic signed [2*AMP_W-1:0]      rnd_x, rnd_y;
    logic signed [TERM_W-1:0]       term_x_reg, term_y_reg;

    // dividers and final sums
    logic                           done_x, done_y;
    logic [DIV_NUM_W-1:0]           quot_x, quot_y;
    logic signed [SUM_W-1:0]        base_x, base_y, ext_x, ext_y, sum_x, sum_y;
    logic [POS_W-1:0]               out_x_reg, out_y_reg;

    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] n, int maxn);
        logic [SIZE_W-1:0] r;
        r = n;
        if (n < SIZE_W'(2)) begin
            r = SIZE_W'(2);
        end else if ({4'b0, n} > 11'(maxn)) begin
            r = SIZE_W'(maxn);
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(logic signed [SUM_W-1:0] v);
        logic [POS_W-1:0] r;
        r = v[POS_W-1:0];
        if (v > SUM_W'(32767)) begin
            r = 16'h7fff;
        end else if (v < -SUM_W'(32768)) begin
            r = 16'h8000;
        end
        return r;
    endfunction

    // config writes, any known index clears the phase
    always_comb begin
        row_step_next = row_step_reg;
        col_step_next = col_step_reg;
        amp_x_next    = amp_x_reg;
        amp_y_next    = amp_y_reg;
        rate_next     = rate_reg;
        split_next    = split_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        cfg_hit       = 1'b0;
        if (cfg_valid) begin
            cfg_hit = 1'b1;
            case (cfg_index)
                REG_ROW_STEP: row_step_next = cfg_data[PHASE_W-1:0];
                REG_COL_STEP: col_step_next = cfg_data[PHASE_W-1:0];
                REG_AMP_X:    amp_x_next    = cfg_data[AMP_W-1:0];
                REG_AMP_Y:    amp_y_next    = cfg_data[AMP_W-1:0];
                REG_RATE:     rate_next     = cfg_data[RATE_W-1:0];
                REG_SPLIT:    split_next    = cfg_data[0];
                REG_COLS:     cols_next     = cfg_data[SIZE_W-1:0];
                REG_ROWS:     rows_next     = cfg_data[SIZE_W-1:0];
                default:      cfg_hit       = 1'b0;
            endcase
        end
        phase_next = phase_reg;
        if (cfg_hit) begin
            phase_next = '0;
        end else if (cmd.tadd) begin
            phase_next = phase_reg + delta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_step_reg <= '0;
            col_step_reg <= '0;
            amp_x_reg    <= '0;
            amp_y_reg    <= '0;
            rate_reg     <= '0;
            split_reg    <= 1'b0;
            cols_reg     <= SIZE_W'(2);
            rows_reg     <= SIZE_W'(2);
            phase_reg    <= '0;
        end else begin
            row_step_reg <= row_step_next;
            col_step_reg <= col_step_next;
            amp_x_reg    <= amp_x_next;
            amp_y_reg    <= amp_y_next;
            rate_reg     <= rate_next;
            split_reg    <= split_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            phase_reg    <= phase_next;
        end
    end

    // time step times rate, keep bits 31:16
    assign time_prod = $signed({1'b0, time_reg}) * rate_reg;

    // vertex setup logic
    assign cols_n   = clamp_size(cols_reg, MAX_COLS);
    assign rows_n   = clamp_size(rows_reg, MAX_ROWS);
    assign den_x    = cols_n - 1'b1;
    assign den_y    = rows_n - 1'b1;
    assign num_x    = {col_reg, {FRAC_W{1'b0}}} + DIV_NUM_W'(den_x >> 1);
    assign num_y    = {row_reg, {FRAC_W{1'b0}}} + DIV_NUM_W'(den_y >> 1);
    assign row_prod = (IDX_W+PHASE_W)'(row_reg) * (IDX_W+PHASE_W)'(row_step_reg);
    assign col_prod = (IDX_W+PHASE_W)'(col_reg) * (IDX_W+PHASE_W)'(col_step_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            time_reg <= in_time;
            col_reg  <= in_col;
            row_reg  <= in_row;
        end
        if (cmd.tmul) begin
            delta_reg <= time_prod[31:16];
        end
        if (cmd.vprep) begin
            ph_x_reg      <= phase_reg + row_prod[PHASE_W-1:0];
            ph_y_reg      <= phase_reg + col_prod[PHASE_W-1:0] + 16'h4000;
            split_hit_reg <= split_reg && ({1'b0, col_reg} >= (cols_n >> 1));
        end
    end

    // quarter-wave rom, filled from the polynomial at elaboration
    for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
        localparam longint T_Q30 = (longint'(k) << 30) / SINE_ENTRIES;
        assign sine_rom[k] = sine_poly(T_Q30);
    end

    // mirror odd quadrants, scale position to a rom address
    always_comb begin
        pos_x_q = {1'b0, ph_x_reg[FRAC_W-1:0]};
        pos_y_q = {1'b0, ph_y_reg[FRAC_W-1:0]};
        if (ph_x_reg[FRAC_W]) pos_x_q = 15'h4000 - pos_x_q;
        if (ph_y_reg[FRAC_W]) pos_y_q = 15'h4000 - pos_y_q;
    end

    assign scaled_x = 32'(pos_x_q) * 32'(SINE_ENTRIES);
    assign scaled_y = 32'(pos_y_q) * 32'(SINE_ENTRIES);
    assign addr_x   = scaled_x[ADDR_W+FRAC_W-1:FRAC_W];
    assign addr_y   = scaled_y[ADDR_W+FRAC_W-1:FRAC_W];

    always_ff @(posedge aclk) begin
        rom_x_reg <= sine_rom[addr_x];
        rom_y_reg <= sine_rom[addr_y];
        neg_x_reg <= ph_x_reg[PHASE_W-1];
        neg_y_reg <= ph_y_reg[PHASE_W-1];
    end

    // sine times amplitude, round half up back to q14
    assign sine_x = neg_x_reg ? -$signed({1'b0, rom_x_reg}) : $signed({1'b0, rom_x_reg});
    assign sine_y = neg_y_reg ? -$signed({1'b0, rom_y_reg}) : $signed({1'b0, rom_y_reg});
    assign prod_x = sine_x * amp_x_reg;
    assign prod_y = sine_y * amp_y_reg;
    assign rnd_x  = prod_x + 32'sd8192;
    assign rnd_y  = prod_y + 32'sd8192;

    always_ff @(posedge aclk) begin
        if (cmd.vmul) begin
            term_x_reg <= rnd_x[2*AMP_W-1:FRAC_W];
            term_y_reg <= rnd_y[2*AMP_W-1:FRAC_W];
        end
    end

    wgvw_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.vprep),
        .num     (num_x),
        .den     (den_x),
        .done    (done_x),
        .quot    (quot_x)
    );

    wgvw_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.vprep),
        .num     (num_y),
        .den     (den_y),
        .done    (done_y),
        .quot    (quot_y)
    );

    assign stat.div_done = done_x && done_y;

    // centered base plus or minus wave, then saturate
    assign base_x = $signed({{(SUM_W-DIV_NUM_W){1'b0}}, quot_x}) - SUM_W'(8192);
    assign base_y = $signed({{(SUM_W-DIV_NUM_W){1'b0}}, quot_y}) - SUM_W'(8192);
    assign ext_x  = {{(SUM_W-TERM_W){term_x_reg[TERM_W-1]}}, term_x_reg};
    assign ext_y  = {{(SUM_W-TERM_W){term_y_reg[TERM_W-1]}}, term_y_reg};
    assign sum_x  = split_hit_reg ? (base_x + ext_x) : (base_x - ext_x);
    assign sum_y  = base_y + ext_y;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_x_reg <= sat_pos(sum_x);
            out_y_reg <= sat_pos(sum_y);
        end
    end

    assign pos_x = out_x_reg;
    assign pos_y = out_y_reg;

endmodule

/* design/wgvw_ctrl.sv */
// controller state machine for the wavy grid vertex warp
module wgvw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  wgvw_pkg::wgvw_stat_t stat,
    output wgvw_pkg::wgvw_cmd_t  cmd
);
    import wgvw_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_TMUL  = 8'b0000_0010,
        ST_TADD  = 8'b0000_0100,
        ST_VPREP = 8'b0000_1000,
        ST_VROM  = 8'b0001_0000,
        ST_VMUL  = 8'b0010_0000,
        ST_VWAIT = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        valid_next = valid_reg;
        if (valid_reg && m_tready) valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = (s_tuser == OP_VERTEX) ? ST_VPREP : ST_TMUL;
                end
            end
            ST_TMUL: begin
                cmd.tmul   = 1'b1;
                state_next = ST_TADD;
            end
            ST_TADD: begin
                cmd.tadd   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_VPREP: begin
                cmd.vprep  = 1'b1;
                state_next = ST_VROM;
            end
            ST_VROM: begin
                state_next = ST_VMUL;
            end
            ST_VMUL: begin
                cmd.vmul   = 1'b1;
                state_next = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (stat.div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

`ifndef ASSERT_OFF
    a_emit_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.div_done)
        else $error("output loaded before division finished");

    a_advance_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_ADVANCE) |=> cmd.tmul ##1 cmd.tadd)
        else $error("time advance sequence broken");

    a_vertex_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_VERTEX) |=> cmd.vprep)
        else $error("vertex setup not started after accept");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");
`endif

endmodule

/* design/wavy_grid_vertex_warp_top.sv */
// top level of the wavy grid vertex warp: stream ports, config port, controller and datapath
//
// Sinusoidal mesh warp in Q2.14 fixed point. A word with tuser opcode 0 advances the
// 16-bit wave phase by floor(time_step * phase_rate / 65536) and gives no result; it
// is done as a 16x24 multiply, then the accumulate. A word with opcode 1 queries
// vertex (col,row) and gives one result word with pos_x and pos_y: the centered grid
// position, minus (or in split mode, plus for the right half) sin(phase + row*row_phase_step)
// times amp_x, and plus cos(phase + col*col_phase_step) times amp_y, saturated to 16 bits.
// A vertex result is presented once both dividers are done and the output register is free,
// and the next word is taken only after the result is loaded. The wait is set
// by the two restoring dividers (col/(cols-1) and row/(rows-1), one quotient bit per cycle,
// 20 bits) that run side by side while the sine rom and amplitude multiply finish.
// The sine comes from a quarter-wave rom of SINE_ENTRIES+1 entries with registered reads.
// A finished result sits in the output register so the next word can be accepted while it
// waits. Config writes are taken at any time on cfg_valid (cfg_ready is always high) but
// must only be issued while the block is idle; a write to any known index clears the phase,
// writes to indexes 8 and up are ignored.
module wavy_grid_vertex_warp_top #(
    parameter int SINE_ENTRIES = wgvw_pkg::SINE_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wgvw_pkg::S_DATA_W-1:0]   s_tdata,   // time_step[15:0], col[21:16], row[27:22], zero
    input  logic                            s_tuser,   // opcode[0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wgvw_pkg::M_DATA_W-1:0]   m_tdata,   // pos_x[15:0], pos_y[31:16]
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wgvw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wgvw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wgvw_pkg::*;

    wgvw_cmd_t          cmd;
    wgvw_stat_t         stat;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [TIME_W-1:0]  in_time;
    logic [IDX_W-1:0]   in_col;
    logic [IDX_W-1:0]   in_row;
    logic               cfg_wr;

    // unpack input word fields
    assign in_time = s_tdata[TIME_W-1:0];
    assign in_col  = s_tdata[TIME_W+IDX_W-1:TIME_W];
    assign in_row  = s_tdata[TIME_W+2*IDX_W-1:TIME_W+IDX_W];

    // config writes land in the config registers directly, no backpressure needed
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    wgvw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wgvw_dp #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_time   (in_time),
        .in_col    (in_col),
        .in_row    (in_row),
        .cmd       (cmd),
        .stat      (stat),
        .pos_x     (pos_x),
        .pos_y     (pos_y)
    );

    // pack result word
    assign m_tdata = {pos_y, pos_x};

endmodule
